>>> hdl/midpoint_ellipse_rasterizer_defines.svh
// Assertion macros for the midpoint ellipse rasterizer checker.
// No dependencies.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_DEFINES_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_DEFINES_SVH

// same-cycle implication
`define MER_ASSERT_IMP(lbl, clk, rstn, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) else $error(msg);

// next-cycle implication
`define MER_ASSERT_NXT(lbl, clk, rstn, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error(msg);

`endif

>>> hdl/mer_pkg.sv
// Types and constants shared by the midpoint ellipse rasterizer modules.
// No dependencies.
package mer_pkg;

    localparam int PIX_W    = 13;
    localparam int TDATA_W  = 32;
    localparam int TUSER_W  = 2;
    localparam int SDATA_W  = 8;

    localparam logic [1:0] CFG_CENTER_X = 2'd0;
    localparam logic [1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [1:0] CFG_RADIUS_X = 2'd2;
    localparam logic [1:0] CFG_RADIUS_Y = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_REG1,
        PH_REG2,
        PH_DONE
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_I_PROD,
        ST_I_SUM,
        ST_I_RND,
        ST_S_PROD,
        ST_S_SUM,
        ST_S_RND,
        ST_S_CHK,
        ST_EMIT,
        ST_DONE
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT_SQ,
        OP_INIT_PROD,
        OP_INIT_SUM,
        OP_SW_SQ,
        OP_SW_PROD,
        OP_SW_SUM,
        OP_ROUND,
        OP_STEP1,
        OP_STEP2
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic       load_out;
        logic       out_done;
        logic [1:0] out_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic reg1_go;
        logic reg2_go;
    } dp_stat_t;

endpackage

>>> hdl/mer_dpath.sv
// Datapath: configuration, ellipse state, multipliers, rounding and output item register.
// Depends on mer_pkg; driven by mer_ctrl.
module mer_dpath #(
    parameter int RADIUS_BITS = 10,
    parameter int COORD_BITS  = 11
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS)-1:0] cfg_wdata,
    input  mer_pkg::dp_cmd_t        cmd,
    output mer_pkg::dp_stat_t       stat,
    output logic [mer_pkg::TDATA_W-1:0] m_tdata,  // pixel_x, pixel_y, zero fill
    output logic [mer_pkg::TUSER_W-1:0] m_tuser,  // is_pixel, done_res
    output logic                    m_tlast
);
    import mer_pkg::*;

    localparam int R     = RADIUS_BITS;
    localparam int SQ_W  = 2 * R;
    localparam int X_W   = R + 1;
    localparam int TX_W  = R + 2;
    localparam int TX2_W = 2 * TX_W;
    localparam int M1_W  = SQ_W + TX2_W;
    localparam int M2_W  = 2 * SQ_W;
    localparam int CR_W  = 3 * R + 2;
    localparam int DEC_W = 4 * R + 8;
    localparam int SUM_A = (COORD_BITS > X_W) ? COORD_BITS : X_W;
    localparam int SUM_W = (SUM_A > PIX_W) ? SUM_A : PIX_W;

    logic [COORD_BITS-1:0] center_x_reg, center_y_reg, cx_reg, cy_reg;
    logic [R-1:0]          radius_x_reg, radius_y_reg, step_y_reg;
    logic [X_W-1:0]        step_x_reg;
    logic [SQ_W-1:0]       rx2_reg, ry2_reg, ty2_reg;
    logic [TX2_W-1:0]      tx2_reg;
    logic [M1_W-1:0]       m1_reg;
    logic [M2_W-1:0]       m2_reg, m3_reg;
    logic [CR_W-1:0]       cross_x_reg, cross_y_reg;
    logic signed [DEC_W-1:0] dec_reg, q_reg;
    logic [PIX_W-1:0]      pix_x_reg, pix_y_reg;
    logic                  isp_reg, done_reg, last_reg;

    logic [CR_W-1:0]         cx_n, cy_n;
    logic signed [DEC_W-1:0] rx2_s, ry2_s, cxn_s, cyn_s, m1_s, m2_s, m3_s;
    logic signed [DEC_W-1:0] step1_dec, step2_dec, q_mag, rnd_mag, rnd_dec;
    logic [TX_W-1:0]         tx;
    logic [R-1:0]            ty;
    logic [SUM_W-1:0]        cx_e, cy_e, sx_e, sy_e, px_sum, py_sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_x_reg <= '0;
            radius_y_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_CENTER_X: center_x_reg <= cfg_wdata[COORD_BITS-1:0];
                CFG_CENTER_Y: center_y_reg <= cfg_wdata[COORD_BITS-1:0];
                CFG_RADIUS_X: radius_x_reg <= cfg_wdata[R-1:0];
                CFG_RADIUS_Y: radius_y_reg <= cfg_wdata[R-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cx_n  = cross_x_reg + CR_W'({ry2_reg, 1'b0});
        cy_n  = cross_y_reg - CR_W'({rx2_reg, 1'b0});
        rx2_s = $signed(DEC_W'(rx2_reg));
        ry2_s = $signed(DEC_W'(ry2_reg));
        cxn_s = $signed(DEC_W'(cx_n));
        cyn_s = $signed(DEC_W'(cy_n));
        m1_s  = $signed(DEC_W'(m1_reg));
        m2_s  = $signed(DEC_W'(m2_reg));
        m3_s  = $signed(DEC_W'(m3_reg));
        if (dec_reg < 0) begin
            step1_dec = dec_reg + ry2_s + cxn_s;
        end else begin
            step1_dec = dec_reg + ry2_s + cxn_s - cyn_s;
        end
        if (dec_reg > 0) begin
            step2_dec = dec_reg + rx2_s - cyn_s;
        end else begin
            step2_dec = dec_reg + rx2_s - cyn_s + cxn_s;
        end
        q_mag   = q_reg[DEC_W-1] ? -q_reg : q_reg;
        rnd_mag = (q_mag + DEC_W'(2)) >>> 2;
        rnd_dec = q_reg[DEC_W-1] ? -rnd_mag : rnd_mag;
        tx      = {step_x_reg, 1'b1};
        ty      = (step_y_reg == '0) ? R'(1) : step_y_reg - R'(1);
        cx_e    = SUM_W'(cx_reg);
        cy_e    = SUM_W'(cy_reg);
        sx_e    = SUM_W'(step_x_reg);
        sy_e    = SUM_W'(step_y_reg);
        px_sum  = cmd.out_sel[0] ? cx_e - sx_e : cx_e + sx_e;
        py_sum  = cmd.out_sel[1] ? cy_e - sy_e : cy_e + sy_e;
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_INIT_SQ: begin
                cx_reg      <= center_x_reg;
                cy_reg      <= center_y_reg;
                rx2_reg     <= SQ_W'(radius_x_reg) * SQ_W'(radius_x_reg);
                ry2_reg     <= SQ_W'(radius_y_reg) * SQ_W'(radius_y_reg);
                step_x_reg  <= '0;
                step_y_reg  <= radius_y_reg;
                cross_x_reg <= '0;
            end
            OP_INIT_PROD: m3_reg <= M2_W'(rx2_reg) * M2_W'(step_y_reg);
            OP_INIT_SUM: begin
                cross_y_reg <= CR_W'({m3_reg, 1'b0});
                q_reg       <= (ry2_s <<< 2) - (m3_s <<< 2) + rx2_s;
            end
            OP_SW_SQ: begin
                tx2_reg <= TX2_W'(tx) * TX2_W'(tx);
                ty2_reg <= SQ_W'(ty) * SQ_W'(ty);
            end
            OP_SW_PROD: begin
                m1_reg <= M1_W'(ry2_reg) * M1_W'(tx2_reg);
                m2_reg <= M2_W'(rx2_reg) * M2_W'(ty2_reg);
                m3_reg <= M2_W'(rx2_reg) * M2_W'(ry2_reg);
            end
            OP_SW_SUM: q_reg <= m1_s + (m2_s <<< 2) - (m3_s <<< 2);
            OP_ROUND: dec_reg <= rnd_dec;
            OP_STEP1: begin
                step_x_reg  <= step_x_reg + X_W'(1);
                cross_x_reg <= cx_n;
                dec_reg     <= step1_dec;
                if (dec_reg >= 0) begin
                    step_y_reg  <= step_y_reg - R'(1);
                    cross_y_reg <= cy_n;
                end
            end
            OP_STEP2: begin
                step_y_reg  <= step_y_reg - R'(1);
                cross_y_reg <= cy_n;
                dec_reg     <= step2_dec;
                if (dec_reg <= 0) begin
                    step_x_reg  <= step_x_reg + X_W'(1);
                    cross_x_reg <= cx_n;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            if (cmd.out_done) begin
                pix_x_reg <= '0;
                pix_y_reg <= '0;
                isp_reg   <= 1'b0;
                done_reg  <= 1'b1;
                last_reg  <= 1'b1;
            end else begin
                pix_x_reg <= px_sum[PIX_W-1:0];
                pix_y_reg <= py_sum[PIX_W-1:0];
                isp_reg   <= 1'b1;
                done_reg  <= 1'b0;
                last_reg  <= (cmd.out_sel == 2'd3);
            end
        end
    end

    assign stat.reg1_go = (cross_x_reg < cross_y_reg);
    assign stat.reg2_go = (step_y_reg != '0);
    assign m_tdata = {{(TDATA_W - 2 * PIX_W){1'b0}}, pix_y_reg, pix_x_reg};
    assign m_tuser = {done_reg, isp_reg};
    assign m_tlast = last_reg;

endmodule

>>> hdl/mer_ctrl.sv
// Controller: ellipse phase, sequencing of set-up and steps, output handshake.
// Depends on mer_pkg; commands mer_dpath.
module mer_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              restart,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  mer_pkg::dp_stat_t stat,
    output mer_pkg::dp_cmd_t  cmd
);
    import mer_pkg::*;

    ctrl_state_t state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [1:0]  k_reg, k_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic        out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_IDLE;
            k_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            k_reg        <= k_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        k_next        = k_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        s_tready      = 1'b0;
        cmd           = '{op: OP_NONE, load_out: 1'b0, out_done: 1'b0, out_sel: k_reg};
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                k_next   = '0;
                if (s_tvalid) begin
                    if (restart) begin
                        cmd.op     = OP_INIT_SQ;
                        state_next = ST_I_PROD;
                    end else begin
                        priority if (phase_reg == PH_REG1 && stat.reg1_go) begin
                            cmd.op     = OP_STEP1;
                            state_next = ST_EMIT;
                        end else if (phase_reg == PH_REG1) begin
                            cmd.op     = OP_SW_SQ;
                            state_next = ST_S_PROD;
                        end else if (phase_reg == PH_REG2 && stat.reg2_go) begin
                            cmd.op     = OP_STEP2;
                            state_next = ST_EMIT;
                        end else if (phase_reg == PH_REG2) begin
                            phase_next = PH_DONE;
                            state_next = ST_DONE;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_I_PROD: begin
                cmd.op     = OP_INIT_PROD;
                state_next = ST_I_SUM;
            end
            ST_I_SUM: begin
                cmd.op     = OP_INIT_SUM;
                state_next = ST_I_RND;
            end
            ST_I_RND: begin
                cmd.op     = OP_ROUND;
                phase_next = PH_REG1;
                state_next = ST_EMIT;
            end
            ST_S_PROD: begin
                cmd.op     = OP_SW_PROD;
                state_next = ST_S_SUM;
            end
            ST_S_SUM: begin
                cmd.op     = OP_SW_SUM;
                state_next = ST_S_RND;
            end
            ST_S_RND: begin
                cmd.op     = OP_ROUND;
                phase_next = PH_REG2;
                state_next = ST_S_CHK;
            end
            ST_S_CHK: begin
                if (stat.reg2_go) begin
                    cmd.op     = OP_STEP2;
                    state_next = ST_EMIT;
                end else begin
                    phase_next = PH_DONE;
                    state_next = ST_DONE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.load_out  = 1'b1;
                    m_tvalid_next = 1'b1;
                    k_next        = k_reg + 2'd1;
                    if (k_reg == 2'd3) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.load_out  = 1'b1;
                    cmd.out_done  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

>>> hdl/midpoint_ellipse_rasterizer.sv
// Advance: the step at accept, then four pixel items.
// Restart: squares, product, sum, rounding, then four items.
// Region switch: squares, three products, sum, rounding, step, four items (or the done item when step_y is zero).
// Rate is set by the single output register, one item per cycle while m_tready is high, one input item at a time.
// Reset (aresetn low, synchronous) clears the config registers, idles the ellipse and empties the output.
module midpoint_ellipse_rasterizer #(
    parameter int RADIUS_BITS = 10,
    parameter int COORD_BITS  = 11
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS)-1:0] cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [mer_pkg::SDATA_W-1:0] s_tdata,  // restart, zero fill
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [mer_pkg::TDATA_W-1:0] m_tdata,  // pixel_x, pixel_y, zero fill
    output logic [mer_pkg::TUSER_W-1:0] m_tuser,  // is_pixel, done_res
    output logic                        m_tlast
);
    import mer_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    mer_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .restart  (s_tdata[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mer_dpath #(
        .RADIUS_BITS (RADIUS_BITS),
        .COORD_BITS  (COORD_BITS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

>>> hdl/mer_checker.sv
// Port-level checks for the midpoint ellipse rasterizer, bound to the top level.
// Depends on mer_pkg and midpoint_ellipse_rasterizer_defines.svh.
`include "midpoint_ellipse_rasterizer_defines.svh"
module mer_port_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [mer_pkg::TUSER_W-1:0] m_tuser,
    input logic                        m_tlast
);
    import mer_pkg::*;

    `MER_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "item dropped")
    `MER_ASSERT_IMP(a_done_last, aclk, aresetn, m_tvalid && m_tuser[1], m_tlast, "done not last")
    `MER_ASSERT_IMP(a_done_pix, aclk, aresetn, m_tvalid && m_tuser[1], !m_tuser[0], "done pixel")
    `MER_ASSERT_IMP(a_rdy_last, aclk, aresetn, s_tready && m_tvalid, m_tlast, "early accept")

endmodule

bind midpoint_ellipse_rasterizer mer_port_checker u_mer_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> tb/sv/mer_checker.sv
// Checker for the midpoint ellipse rasterizer: watches the config port and both
// streams, predicts the pixel items and compares them. Depends on mer_pkg.
module mer_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [10:0]                 cfg_wdata,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [mer_pkg::SDATA_W-1:0] s_tdata,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [mer_pkg::TDATA_W-1:0] m_tdata,
    input  logic [mer_pkg::TUSER_W-1:0] m_tuser,
    input  logic                        m_tlast,
    output int                          fail_count,
    output int                          pending
);
    import mer_pkg::*;

    typedef struct packed {
        logic [12:0] px;
        logic [12:0] py;
        logic        is_pixel;
        logic        done_res;
        logic        last;
    } pixel_item_t;

    pixel_item_t pixel_q[$];

    logic [10:0] reg_cx, reg_cy;
    logic [9:0]  reg_rx, reg_ry;
    phase_t      ph;
    longint      sx, sy, crx, cry, dec, lcx, lcy, rx2, ry2;

    assign pending = pixel_q.size();

    function automatic longint round_q(longint q);
        if (q >= 0) return (q + 2) / 4;
        return -((-q + 2) / 4);
    endfunction

    task automatic push_four();
        pixel_item_t it;
        for (int k = 0; k < 4; k++) begin
            it.px = 13'(lcx + ((k % 2) ? -sx : sx));
            it.py = 13'(lcy + ((k / 2) ? -sy : sy));
            it.is_pixel = 1'b1;
            it.done_res = 1'b0;
            it.last = (k == 3);
            pixel_q.push_back(it);
        end
    endtask

    task automatic predict_item(logic restart);
        pixel_item_t it;
        longint tx, ty, rx, ry;
        if (restart) begin
            rx = reg_rx;
            ry = reg_ry;
            lcx = reg_cx;
            lcy = reg_cy;
            rx2 = rx * rx;
            ry2 = ry * ry;
            sx = 0;
            sy = ry;
            crx = 0;
            cry = 2 * rx2 * ry;
            dec = round_q(4 * ry2 - 4 * rx2 * ry + rx2);
            ph = PH_REG1;
            push_four();
            return;
        end
        if (ph == PH_REG1) begin
            if (crx < cry) begin
                sx++;
                crx += 2 * ry2;
                if (dec < 0) begin
                    dec += ry2 + crx;
                end else begin
                    sy--;
                    cry -= 2 * rx2;
                    dec += ry2 + crx - cry;
                end
                push_four();
                return;
            end
            tx = 2 * sx + 1;
            ty = sy - 1;
            dec = round_q(ry2 * tx * tx + 4 * rx2 * ty * ty - 4 * rx2 * ry2);
            ph = PH_REG2;
        end
        if (ph == PH_REG2) begin
            if (sy > 0) begin
                sy--;
                cry -= 2 * rx2;
                if (dec > 0) begin
                    dec += rx2 - cry;
                end else begin
                    sx++;
                    crx += 2 * ry2;
                    dec += rx2 - cry + crx;
                end
                push_four();
                return;
            end
            ph = PH_DONE;
        end
        it = '{13'd0, 13'd0, 1'b0, 1'b1, 1'b1};
        pixel_q.push_back(it);
    endtask

    always @(posedge aclk) begin
        pixel_item_t got, want;
        if (!aresetn) begin
            reg_cx <= '0;
            reg_cy <= '0;
            reg_rx <= '0;
            reg_ry <= '0;
            ph = PH_IDLE;
            sx = 0; sy = 0; crx = 0; cry = 0; dec = 0;
            lcx = 0; lcy = 0; rx2 = 0; ry2 = 0;
            pixel_q.delete();
            fail_count <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_CENTER_X: reg_cx <= cfg_wdata;
                    CFG_CENTER_Y: reg_cy <= cfg_wdata;
                    CFG_RADIUS_X: reg_rx <= cfg_wdata[9:0];
                    CFG_RADIUS_Y: reg_ry <= cfg_wdata[9:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) predict_item(s_tdata[0]);
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[12:0], m_tdata[25:13], m_tuser[0], m_tuser[1], m_tlast};
                if (pixel_q.size() == 0) begin
                    $display("%0t: unexpected item, actual %h", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = pixel_q.pop_front();
                    if (got !== want || m_tdata[31:26] !== 6'd0) begin
                        $display("%0t: expected %h, actual %h", $time, want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

>>> tb/sv/tb_midpoint_ellipse_rasterizer.sv
// Top of the midpoint ellipse rasterizer testbench: clock, reset, config and
// stimulus, verdict. Depends on mer_pkg, mer_checker and the block.
module tb_midpoint_ellipse_rasterizer;
    import mer_pkg::*;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [1:0]           cfg_index = CFG_CENTER_X;
    logic [10:0]          cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [SDATA_W-1:0]   s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic [TUSER_W-1:0]   m_tuser;
    logic                 m_tlast;
    int                   fail_count, pending;
    int                   cycles = 0;
    bit                   calm = 1'b0;
    bit                   hold_long = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    midpoint_ellipse_rasterizer dut (.*);

    mer_checker chk (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off
    initial begin
        int n;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_long) begin
                m_tready <= 1'b0;
                repeat (300) @(negedge aclk);
                hold_long = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 7);
                m_tready <= 1'b0;
                repeat (n - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [10:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_ellipse(int cx, int cy, int rx, int ry);
        write_reg(CFG_CENTER_X, 11'(cx));
        write_reg(CFG_CENTER_Y, 11'(cy));
        write_reg(CFG_RADIUS_X, 11'(rx));
        write_reg(CFG_RADIUS_Y, 11'(ry));
    endtask

    task automatic send(logic restart);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, restart};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    initial begin
        int len;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        // advance before any restart, then zero radii
        send(1'b0);
        send(1'b1);
        send(1'b0);
        send(1'b0);
        drain();
        set_ellipse(2047, 2047, 1023, 1023);
        send(1'b1);
        repeat (3) send(1'b0);
        send(1'b1);
        drain();
        set_ellipse(0, 0, 1023, 0);
        send(1'b1);
        repeat (3) send(1'b0);
        drain();
        set_ellipse(5, 1000, 0, 7);
        send(1'b1);
        repeat (10) send(1'b0);
        drain();
        set_ellipse(700, 300, 5, 3);
        hold_long = 1'b1;
        send(1'b1);
        repeat (10) send(1'b0);
        drain();
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) calm = 1'b1;
            if (ph == 2)
                set_ellipse($urandom_range(0, 2047), $urandom_range(0, 2047),
                            $urandom_range(512, 1023), $urandom_range(512, 1023));
            else
                set_ellipse($urandom_range(0, 2047), $urandom_range(0, 2047),
                            $urandom_range(0, 12), $urandom_range(0, 12));
            len = 0;
            while (len < 22) begin
                send($urandom_range(0, 9) == 0);
                len++;
            end
            drain();
        end
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
